// ===== sv/npcm_pkg.sv =====
`timescale 1ns / 1ps

package npcm_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic load_out;
	} npcm_cmd_t;

	typedef struct packed {
		logic start_scan;
		logic last_issue;
	} npcm_status_t;

	localparam logic [1:0] KIND_DEFAULT = 2'd0;
	localparam logic [1:0] KIND_NAMED   = 2'd1;
	localparam logic [1:0] KIND_RGB     = 2'd2;

	localparam logic [8:0] RESULT_NONE = 9'h1FF;
	localparam logic [8:0] ROM_DEPTH   = 9'd256;

	localparam logic [7:0] CUBE_FIRST = 8'd16;
	localparam logic [7:0] GRAY_FIRST = 8'd232;
	localparam logic [7:0] GRAY_BASE  = 8'h08;
	localparam logic [7:0] GRAY_STEP  = 8'd10;
	localparam logic [2:0] CUBE_LAST  = 3'd5;

	localparam rgb_t SYS_RGB [16] = '{
		'{8'h00, 8'h00, 8'h00}, '{8'h80, 8'h00, 8'h00},
		'{8'h00, 8'h80, 8'h00}, '{8'h80, 8'h80, 8'h00},
		'{8'h00, 8'h00, 8'h80}, '{8'h80, 8'h00, 8'h80},
		'{8'h00, 8'h80, 8'h80}, '{8'hc0, 8'hc0, 8'hc0},
		'{8'h80, 8'h80, 8'h80}, '{8'hff, 8'h00, 8'h00},
		'{8'h00, 8'hff, 8'h00}, '{8'hff, 8'hff, 8'h00},
		'{8'h00, 8'h00, 8'hff}, '{8'hff, 8'h00, 8'hff},
		'{8'h00, 8'hff, 8'hff}, '{8'hff, 8'hff, 8'hff}
	};

	localparam logic [7:0] CUBE_LEVEL [6] = '{8'h00, 8'h5f, 8'h87, 8'haf, 8'hd7, 8'hff};

endpackage

// ===== sv/npcm_ctrl.sv =====
`timescale 1ns / 1ps

module npcm_ctrl
	import npcm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  npcm_status_t status,
	output npcm_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = status.start_scan ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.last_issue) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.load_out = !out_valid_q || !out_stall;
				if (cmd.load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== sv/npcm_datapath.sv =====
`timescale 1ns / 1ps

module npcm_datapath
	import npcm_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [8:0]        cfg_wr_data,
	input  logic [1:0]        color_kind,
	input  logic [2:0]        named_index,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  npcm_cmd_t         cmd,
	output npcm_status_t      status,
	output logic signed [8:0] palette_index
);

	localparam logic [8:0] ENTRY_LIMIT = (PALETTE_ENTRIES > 256) ? ROM_DEPTH :
		9'(PALETTE_ENTRIES);

	logic [8:0]  palette_size_q;
	logic [8:0]  limit;
	rgb_t        color_q;
	logic [8:0]  idx_q;
	logic [2:0]  dig_r_q;
	logic [2:0]  dig_g_q;
	logic [2:0]  dig_b_q;
	logic [7:0]  gray_q;
	rgb_t        entry;
	logic [7:0]  diff_r;
	logic [7:0]  diff_g;
	logic [7:0]  diff_b;
	logic        valid_s1;
	logic [7:0]  idx_s1;
	logic [15:0] sq_r_s1;
	logic [15:0] sq_g_s1;
	logic [15:0] sq_b_s1;
	logic [17:0] distance;
	logic [17:0] best_q;
	logic [8:0]  result_q;
	logic [8:0]  index_q;

	assign limit = (palette_size_q > ENTRY_LIMIT) ? ENTRY_LIMIT : palette_size_q;

	assign status.start_scan = (color_kind == KIND_RGB) && (limit != 9'd0);
	assign status.last_issue = (idx_q == limit - 9'd1);

	always_comb begin
		if (idx_q[7:0] < CUBE_FIRST) begin
			entry = SYS_RGB[idx_q[3:0]];
		end else if (idx_q[7:0] < GRAY_FIRST) begin
			entry.r = CUBE_LEVEL[dig_r_q];
			entry.g = CUBE_LEVEL[dig_g_q];
			entry.b = CUBE_LEVEL[dig_b_q];
		end else begin
			entry.r = gray_q;
			entry.g = gray_q;
			entry.b = gray_q;
		end
		diff_r = (color_q.r > entry.r) ? color_q.r - entry.r : entry.r - color_q.r;
		diff_g = (color_q.g > entry.g) ? color_q.g - entry.g : entry.g - color_q.g;
		diff_b = (color_q.b > entry.b) ? color_q.b - entry.b : entry.b - color_q.b;
	end

	assign distance = 18'(sq_r_s1) + 18'(sq_g_s1) + 18'(sq_b_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= ROM_DEPTH;
			valid_s1 <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				palette_size_q <= cfg_wr_data;
			end
			valid_s1 <= cmd.issue;
			if (cmd.accept) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			color_q <= '{red, green, blue};
			dig_r_q <= '0;
			dig_g_q <= '0;
			dig_b_q <= '0;
			gray_q <= GRAY_BASE;
			best_q <= '1;
			result_q <= (color_kind == KIND_NAMED) ? {6'd0, named_index} : RESULT_NONE;
		end else begin
			if (cmd.issue) begin
				if (idx_q[7:0] >= GRAY_FIRST) begin
					gray_q <= gray_q + GRAY_STEP;
				end else if (idx_q[7:0] >= CUBE_FIRST) begin
					if (dig_b_q == CUBE_LAST) begin
						dig_b_q <= '0;
						if (dig_g_q == CUBE_LAST) begin
							dig_g_q <= '0;
							dig_r_q <= dig_r_q + 3'd1;
						end else begin
							dig_g_q <= dig_g_q + 3'd1;
						end
					end else begin
						dig_b_q <= dig_b_q + 3'd1;
					end
				end
			end
			if (valid_s1 && (distance < best_q)) begin
				best_q <= distance;
				result_q <= {1'b0, idx_s1};
			end
		end
		idx_s1 <= idx_q[7:0];
		sq_r_s1 <= 16'(diff_r) * 16'(diff_r);
		sq_g_s1 <= 16'(diff_g) * 16'(diff_g);
		sq_b_s1 <= 16'(diff_b) * 16'(diff_b);
		if (cmd.load_out) begin
			index_q <= result_q;
		end
	end

	assign palette_index = $signed(index_q);

endmodule

// ===== sv/nearest_palette_color_match.sv =====
`timescale 1ns / 1ps

// Nearest palette color match. A request on the input channel carries a color
// kind, a basic color index and an RGB triple. The default color answers -1, a
// basic color answers its own index, and an RGB color answers the closest of
// the first limit palette entries (limit is given below) by squared RGB distance.
// Each channel moves one item per transfer when valid is high and stall is low.
// One request is processed at a time, and in_stall stays high until the result
// has been placed in the output register. A default or basic color goes from
// its transfer straight to the done state and is loaded into the output register
// there. An RGB request scans one palette entry per cycle through a two-stage
// distance datapath over the first limit entries, where limit is the smallest of
// palette_size, PALETTE_ENTRIES and 256, then passes a flush state before its
// result is loaded; with a limit of zero it answers -1 like a default color. The
// next request is taken once the result has entered the output register, not before.
// If the receiver stalls, the waiting result holds and the finished next
// result waits until the register frees up.
// Reset sets palette_size to 256 and empties the block. The register may only
// be written while no request is in progress.

module nearest_palette_color_match
	import npcm_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [8:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        color_kind,
	input  logic [2:0]        named_index,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [8:0] palette_index
);

	npcm_cmd_t    cmd;
	npcm_status_t status;

	npcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	npcm_datapath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.color_kind    (color_kind),
		.named_index   (named_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.cmd           (cmd),
		.status        (status),
		.palette_index (palette_index)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!palette_index[8] || palette_index == -9'sd1))
		else $error("result index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> in_stall)
		else $error("scan running while input open");

endmodule

// ===== tb/sv/nearest_palette_color_match_checker.sv =====
`timescale 1ns / 1ps

module nearest_palette_color_match_checker
	import npcm_pkg::*;
#(
	parameter int ROM_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [8:0]        cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        color_kind,
	input  logic [2:0]        named_index,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic signed [8:0] palette_index,
	output int                mismatches,
	output int                outstanding
);

	logic [8:0] search_size;
	logic [8:0] expected_index_q [$];
	logic [8:0] wanted_index;
	int fail_total = 0;
	int pending_total = 0;

	assign mismatches = fail_total;
	assign outstanding = pending_total;

	function automatic logic [7:0] cube_step(int unsigned digit);
		case (digit)
			0: return 8'h00;
			1: return 8'h5f;
			2: return 8'h87;
			3: return 8'haf;
			4: return 8'hd7;
			default: return 8'hff;
		endcase
	endfunction

	function automatic logic [23:0] entry_rgb(int unsigned entry);
		int unsigned cell_pos;
		logic [7:0] level;
		if (entry < 16) begin
			case (entry)
				0: return 24'h000000;
				1: return 24'h800000;
				2: return 24'h008000;
				3: return 24'h808000;
				4: return 24'h000080;
				5: return 24'h800080;
				6: return 24'h008080;
				7: return 24'hc0c0c0;
				8: return 24'h808080;
				9: return 24'hff0000;
				10: return 24'h00ff00;
				11: return 24'hffff00;
				12: return 24'h0000ff;
				13: return 24'hff00ff;
				14: return 24'h00ffff;
				default: return 24'hffffff;
			endcase
		end else if (entry < 232) begin
			cell_pos = entry - 16;
			return {cube_step((cell_pos / 36) % 6), cube_step((cell_pos / 6) % 6),
				cube_step(cell_pos % 6)};
		end
		level = 8'(8 + 10 * (entry - 232));
		return {level, level, level};
	endfunction

	function automatic int unsigned channel_square(logic [7:0] a, logic [7:0] c);
		int d;
		d = int'(a) - int'(c);
		return d * d;
	endfunction

	function automatic logic [8:0] match_color(logic [1:0] kind, logic [2:0] named,
		logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [8:0] size);
		int unsigned span;
		int unsigned best;
		int unsigned distance;
		int unsigned entry;
		logic [23:0] rgb;
		logic [8:0] choice;
		choice = RESULT_NONE;
		if (kind == KIND_NAMED) begin
			choice = {6'd0, named};
		end else if (kind == KIND_RGB) begin
			span = 32'(size);
			if (span > ROM_ENTRIES)
				span = ROM_ENTRIES;
			if (span > 256)
				span = 256;
			best = 32'hFFFF_FFFF;
			for (entry = 0; entry < span; entry++) begin
				rgb = entry_rgb(entry);
				distance = channel_square(r, rgb[23:16]) + channel_square(g, rgb[15:8]) +
					channel_square(b, rgb[7:0]);
				if (distance < best) begin
					best = distance;
					choice = 9'(entry);
				end
			end
		end
		return choice;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_size <= ROM_DEPTH;
			expected_index_q.delete();
			pending_total = 0;
		end else begin
			if (cfg_wr_en)
				search_size <= cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_index_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected transfer: palette_index %0d with no request open",
							palette_index);
				end else begin
					wanted_index = expected_index_q.pop_front();
					if (palette_index !== wanted_index) begin
						fail_total++;
						if (fail_total <= 10)
							$display("palette_index mismatch: expected %0d, got %0d",
								$signed(wanted_index), palette_index);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_index_q = {expected_index_q, match_color(color_kind, named_index,
					red, green, blue, search_size)};
			pending_total = expected_index_q.size();
		end
	end

endmodule

// ===== tb/sv/nearest_palette_color_match_tb.sv =====
`timescale 1ns / 1ps

module nearest_palette_color_match_tb;
	import npcm_pkg::*;

	localparam int PALETTE_ENTRIES = 256;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEMS_PER_PHASE = 127;
	localparam int PHASE_COUNT = 13;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [8:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] color_kind = '0;
	logic [2:0] named_index = '0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [8:0] palette_index;
	int mismatches;
	int outstanding;
	logic calm = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	nearest_palette_color_match #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.color_kind(color_kind),
		.named_index(named_index),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.palette_index(palette_index)
	);

	nearest_palette_color_match_checker #(
		.ROM_ENTRIES(PALETTE_ENTRIES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.color_kind(color_kind),
		.named_index(named_index),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.palette_index(palette_index),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	function automatic int gap_length();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!calm && $urandom_range(0, 3) == 0)
			stall_left = gap_length();
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [7:0] random_channel();
		int pick;
		int base;
		int level_pos;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return 8'($urandom_range(0, 255));
		if (pick == 4)
			return $urandom_range(0, 1) ? 8'hff : 8'h00;
		level_pos = $urandom_range(0, 5);
		case (pick)
			5: base = (level_pos == 0) ? 0 : 55 + 40 * level_pos;
			6: base = 8 + 10 * $urandom_range(0, 23);
			7: base = 75 + 40 * $urandom_range(1, 4);
			default: base = (level_pos < 3) ? 128 : 192;
		endcase
		base = base + $urandom_range(0, 6) - 3;
		if (base < 0)
			base = 0;
		if (base > 255)
			base = 255;
		return 8'(base);
	endfunction

	task automatic send_item(logic [1:0] kind, logic [2:0] named, logic [7:0] r,
		logic [7:0] g, logic [7:0] b);
		if (!calm && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_length()) @(negedge clk);
		end
		color_kind <= kind;
		named_index <= named;
		red <= r;
		green <= g;
		blue <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int pick;
		logic [1:0] kind;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		pick = $urandom_range(0, 19);
		r = random_channel();
		g = random_channel();
		b = random_channel();
		if ($urandom_range(0, 4) == 0) begin
			g = r;
			b = r;
		end
		if (pick < 2)
			kind = KIND_DEFAULT;
		else if (pick == 2)
			kind = KIND_SPARE;
		else if (pick < 6)
			kind = KIND_NAMED;
		else
			kind = KIND_RGB;
		send_item(kind, 3'($urandom_range(0, 7)), r, g, b);
	endtask

	task automatic set_palette_size(logic [8:0] size);
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_data <= size;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 9'($urandom());
		@(negedge clk);
	endtask

	initial begin
		int sizes [PHASE_COUNT];
		int i;
		int n;
		sizes = '{0, 1, 8, 16, 17, 100, 232, 233, 255, 256, 511, 0, 0};
		sizes[11] = $urandom_range(2, 255);
		sizes[12] = $urandom_range(257, 510);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(KIND_DEFAULT, 3'd7, 8'hff, 8'hff, 8'hff);
		send_item(KIND_SPARE, 3'd5, 8'h80, 8'h80, 8'h80);
		for (i = 0; i < 8; i++)
			send_item(KIND_NAMED, 3'(i), random_channel(), random_channel(), random_channel());
		send_item(KIND_NAMED, 3'd7, 8'hff, 8'hff, 8'hff);
		send_item(KIND_RGB, 3'd0, 8'h00, 8'h00, 8'h00);
		send_item(KIND_RGB, 3'd7, 8'hff, 8'hff, 8'hff);
		send_item(KIND_RGB, 3'd3, 8'h80, 8'h80, 8'h80);
		send_item(KIND_RGB, 3'd2, 8'hc0, 8'hc0, 8'hc0);
		send_item(KIND_RGB, 3'd1, 8'h08, 8'h08, 8'h08);
		send_item(KIND_RGB, 3'd6, 8'hee, 8'hee, 8'hee);
		send_item(KIND_RGB, 3'd4, 8'h60, 8'h60, 8'h60);
		send_item(KIND_RGB, 3'd0, 8'hff, 8'h00, 8'h00);
		send_item(KIND_RGB, 3'd5, 8'h00, 8'hff, 8'hff);
		send_item(KIND_RGB, 3'd7, 8'h5f, 8'h87, 8'haf);
		send_item(KIND_RGB, 3'd7, 8'h00, 8'h00, 8'hff);

		for (i = 0; i < PHASE_COUNT; i++) begin
			set_palette_size(9'(sizes[i]));
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 20 == 0)
					calm <= ($urandom_range(0, 3) == 0);
				send_random_item();
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
sv/npcm_pkg.sv
sv/npcm_ctrl.sv
sv/npcm_datapath.sv
sv/nearest_palette_color_match.sv
tb/sv/nearest_palette_color_match_checker.sv
tb/sv/nearest_palette_color_match_tb.sv
